FILE: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, constants and tables of the percussive click synthesizer.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // block constants
    localparam int unsigned SAMPLE_RATE   = 16000;
    localparam int unsigned CLICK_SAMPLES = 400;
    localparam int unsigned NOISE_SAMPLES = 48;

    // field widths
    localparam int unsigned FREQ_W   = 16;
    localparam int unsigned LEVEL_W  = 14;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned PERIOD_W = 14;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = LEVEL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL  = 2'd2;
    localparam logic               RST_CLICK_ENABLE = 1'b1;
    localparam logic [LEVEL_W-1:0] RST_TONE_LEVEL   = 14'd11200;
    localparam logic [LEVEL_W-1:0] RST_NOISE_LEVEL  = 14'd9600;

    // function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [FREQ_W-1:0] DEFAULT_FREQ = 16'd2000;

    // restoring divider: one quotient bit per cycle
    localparam int unsigned DIV_W     = $clog2(SAMPLE_RATE + 1);
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    // seed hash
    localparam logic [31:0] SEED_XOR = 32'h9E3779B9;
    localparam logic [31:0] SEED_MUL = 32'h9E3779B1;

    // envelope exponent, 3.5*log2(e) in Q16, stepped once per sample
    localparam int unsigned ENV_SCALE  = 330919;
    localparam int unsigned ENV_Y_W    = 19;
    localparam int unsigned ENV_STEP_Q = ENV_SCALE / CLICK_SAMPLES;
    localparam int unsigned ENV_STEP_R = ENV_SCALE % CLICK_SAMPLES;
    localparam int unsigned ENV_REM_W  = IDX_W + 1;

    // shared multiplier
    localparam int unsigned MUL_A_W = 18;
    localparam int unsigned MUL_B_W = 33;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic              func;
        logic [FREQ_W-1:0] freq;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_out;

    typedef struct packed {
        logic start_load;
        logic seed_mul;
        logic seed_wr;
        logic div_step;
        logic period_wr;
        logic env_mul;
        logic noise_mul;
        logic mix_mul;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_ctl_status;

    // round(32768 * 2^(-j/16)), j = 0..16
    function automatic logic [15:0] pow2_frac(input logic [4:0] j);
        logic [15:0] v;
        unique case (j)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd31379;
            5'd2:    v = 16'd30048;
            5'd3:    v = 16'd28774;
            5'd4:    v = 16'd27554;
            5'd5:    v = 16'd26386;
            5'd6:    v = 16'd25268;
            5'd7:    v = 16'd24196;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd22188;
            5'd10:   v = 16'd21247;
            5'd11:   v = 16'd20347;
            5'd12:   v = 16'd19484;
            5'd13:   v = 16'd18658;
            5'd14:   v = 16'd17867;
            5'd15:   v = 16'd17109;
            5'd16:   v = 16'd16384;
            default: v = 16'd16384;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: start setup (seed, period division) and per-tick sample steps.
// ----------------------------------------------------------------------------
module pcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_func,
    input  logic                i_click_enable,
    input  pcs_pkg::t_ctl_status i_status,
    output pcs_pkg::t_ctl_cmd   o_cmd,
    output logic                o_in_stall
);
    import pcs_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEED_MUL = 4'd1;
    localparam logic [3:0] S_SEED_WR  = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_PER      = 4'd4;
    localparam logic [3:0] S_ENV      = 4'd5;
    localparam logic [3:0] S_NOISE    = 4'd6;
    localparam logic [3:0] S_MIX      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    logic [3:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_active, n_active;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_active = r_active;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_START) begin
                        if (i_click_enable) begin
                            o_cmd.start_load = 1'b1;
                            n_state          = S_SEED_MUL;
                        end
                    end else if (r_active) begin
                        n_state = S_ENV;
                    end
                end
            end
            S_SEED_MUL: begin
                o_cmd.seed_mul = 1'b1;
                n_state        = S_SEED_WR;
            end
            S_SEED_WR: begin
                o_cmd.seed_wr = 1'b1;
                n_cnt         = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_PER;
                end
            end
            S_PER: begin
                o_cmd.period_wr = 1'b1;
                n_active        = 1'b1;
                n_state         = S_IDLE;
            end
            S_ENV: begin
                o_cmd.env_mul = 1'b1;
                n_state       = S_NOISE;
            end
            S_NOISE: begin
                o_cmd.noise_mul = 1'b1;
                n_state         = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix_mul = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.last) begin
                        n_active = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_active <= n_active;
        end
    end

    a_tick_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_func == FUNC_TICK && r_active)
        |=> (r_state == S_ENV))
        else $error("accepted tick did not start the sample steps");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_LAST) |=> (r_state == S_PER))
        else $error("divider ran past its last quotient bit");

    a_period_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PER) |=> (r_active && r_state == S_IDLE))
        else $error("click not armed after period load");

    a_out_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_status.out_busy) |=> (r_state == S_IDLE))
        else $error("sample transfer did not return to idle");

endmodule

FILE: rtl/core/pcs_dpath.sv
// ----------------------------------------------------------------------------
// pcs_dpath
// Datapath: divider, shared multiplier, noise generator, envelope, output.
// ----------------------------------------------------------------------------
module pcs_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcs_pkg::t_in                i_in,
    input  logic [pcs_pkg::LEVEL_W-1:0] i_tone_level,
    input  logic [pcs_pkg::LEVEL_W-1:0] i_noise_level,
    input  pcs_pkg::t_ctl_cmd           i_cmd,
    output pcs_pkg::t_ctl_status        o_status,
    output pcs_pkg::t_out               o_out,
    output logic                        o_out_valid,
    input  logic                        i_out_stall
);
    import pcs_pkg::*;

    // divider
    logic [FREQ_W-1:0]   r_den;
    logic [FREQ_W-1:0]   r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [FREQ_W:0]     div_trial;
    logic                div_ge;

    // click state
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_phase;
    logic [IDX_W-1:0]    r_index;
    logic [31:0]         r_seed;
    logic [ENV_Y_W-1:0]  r_y;
    logic [ENV_REM_W-1:0] r_yrem;
    logic [14:0]         r_env;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] r_prod;

    t_out r_out;
    logic r_out_valid;

    logic [31:0]          seed_x1, seed_x2, seed_next;
    logic                 noise_on;
    logic [2:0]           env_k;
    logic [3:0]           env_j;
    logic [11:0]          env_r;
    logic [15:0]          env_p0, env_p1, env_diff, env_m, env_sh;
    logic [14:0]          env_val;
    logic signed [MUL_P_W-1:0] prod_adj;
    logic signed [16:0]   noise_val, tone_val, mix_sum;
    logic [ENV_REM_W-1:0] yrem_sum;
    logic                 y_carry;
    logic [IDX_W:0]       index_inc;
    logic                 is_last;
    logic [PERIOD_W:0]    phase_inc;

    // one quotient bit per step
    assign div_trial = {r_rem, r_quo[DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_den});

    // xorshift32
    assign seed_x1   = r_seed ^ (r_seed << 13);
    assign seed_x2   = seed_x1 ^ (seed_x1 >> 17);
    assign seed_next = seed_x2 ^ (seed_x2 << 5);
    assign noise_on  = ({1'b0, r_index} < (IDX_W + 1)'(NOISE_SAMPLES));

    // envelope: piecewise linear 2^-y with y = i*scale/CLICK_SAMPLES
    assign env_k    = r_y[18:16];
    assign env_j    = r_y[15:12];
    assign env_r    = r_y[11:0];
    assign env_p0   = pow2_frac({1'b0, env_j});
    assign env_p1   = pow2_frac(5'({1'b0, env_j}) + 5'd1);
    assign env_diff = env_p0 - env_p1;
    assign env_m    = env_p0 - 16'(r_prod[27:12]);
    assign env_sh   = env_m >> env_k;
    assign env_val  = env_sh[15] ? 15'h7FFF : env_sh[14:0];

    // product / 32768 truncated toward zero
    assign prod_adj  = r_prod + (r_prod[MUL_P_W-1] ? MUL_P_W'(32767) : '0);
    assign noise_val = noise_on ? prod_adj[31:15] : 17'sd0;
    assign tone_val  = (r_phase < (r_period >> 1)) ? $signed({3'b000, i_tone_level})
                                                   : -$signed({3'b000, i_tone_level});
    assign mix_sum   = tone_val + noise_val;

    assign yrem_sum  = r_yrem + ENV_REM_W'(ENV_STEP_R);
    assign y_carry   = (yrem_sum >= ENV_REM_W'(CLICK_SAMPLES));
    assign index_inc = {1'b0, r_index} + 1'b1;
    assign is_last   = (index_inc >= (IDX_W + 1)'(CLICK_SAMPLES));
    assign phase_inc = {1'b0, r_phase} + 1'b1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (i_cmd.seed_mul) begin
            mul_a = $signed({2'b00, r_den});
            mul_b = $signed({1'b0, SEED_MUL});
        end else if (i_cmd.env_mul) begin
            mul_a = $signed({2'b00, env_diff});
            mul_b = $signed({21'd0, env_r});
        end else if (i_cmd.noise_mul) begin
            mul_a = MUL_A_W'($signed({1'b0, r_seed[15:0]}) - 17'sd32768);
            mul_b = $signed({19'd0, i_noise_level});
        end else if (i_cmd.mix_mul) begin
            mul_a = MUL_A_W'(mix_sum);
            mul_b = $signed({18'd0, r_env});
        end
    end

    // product held between uses, so a stalled output keeps its sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_mul || i_cmd.env_mul || i_cmd.noise_mul || i_cmd.mix_mul) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(2);
            r_phase  <= '0;
            r_index  <= '0;
            r_seed   <= '0;
            r_y      <= '0;
            r_yrem   <= '0;
        end else begin
            if (i_cmd.start_load) begin
                r_den   <= (i_in.freq == '0) ? DEFAULT_FREQ : i_in.freq;
                r_rem   <= '0;
                r_quo   <= DIV_W'(SAMPLE_RATE);
                r_phase <= '0;
                r_index <= '0;
                r_y     <= '0;
                r_yrem  <= '0;
            end
            if (i_cmd.seed_wr) begin
                r_seed <= SEED_XOR ^ r_prod[31:0];
            end
            if (i_cmd.div_step) begin
                r_rem <= div_ge ? FREQ_W'(div_trial - {1'b0, r_den}) : div_trial[FREQ_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], div_ge};
            end
            if (i_cmd.period_wr) begin
                r_period <= (r_quo < PERIOD_W'(2)) ? PERIOD_W'(2) : PERIOD_W'(r_quo);
            end
            if (i_cmd.env_mul && noise_on) begin
                r_seed <= seed_next;
            end
            if (i_cmd.noise_mul) begin
                r_env <= env_val;
            end
            if (i_cmd.out_load) begin
                r_phase <= (phase_inc >= {1'b0, r_period}) ? '0 : phase_inc[PERIOD_W-1:0];
                if (is_last) begin
                    r_index <= '0;
                    r_y     <= '0;
                    r_yrem  <= '0;
                end else begin
                    r_index <= index_inc[IDX_W-1:0];
                    r_y     <= r_y + ENV_Y_W'(ENV_STEP_Q) + ENV_Y_W'(y_carry);
                    r_yrem  <= y_carry ? yrem_sum - ENV_REM_W'(CLICK_SAMPLES) : yrem_sum;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.sample <= prod_adj[30:15];
            r_out.last   <= is_last;
        end
    end

    assign o_out           = r_out;
    assign o_out_valid     = r_out_valid;
    assign o_status.last     = is_last;
    assign o_status.out_busy = r_out_valid & i_out_stall;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < r_period)
        else $error("tone phase outside period");

    a_yrem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yrem < ENV_REM_W'(CLICK_SAMPLES))
        else $error("envelope remainder out of range");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && is_last) |=> (r_index == '0 && r_y == '0))
        else $error("index not cleared after final sample");

endmodule

FILE: rtl/core/percussive_click_synth.sv
// ----------------------------------------------------------------------------
// percussive_click_synth
// Percussive click generator: square tone plus attack noise under a
// decaying exponential envelope, one signed sample per tick.
// ----------------------------------------------------------------------------
// A start transfer (func 0) arms a click of CLICK_SAMPLES samples at the given
// frequency (0 selects 2000 Hz) and yields no sample; it is ignored while
// click_enable is 0. While a click runs, each tick transfer (func 1) yields one
// sample, with last set on the final one; ticks while idle yield nothing.
// A start occupies the block through the seed steps, the restoring divider that
// forms the tone period one quotient bit per cycle (14 bits), and the period
// load. A tick runs its sample steps in order, using the
// shared multiplier three times in a row (envelope, noise, mix), then loads the output;
// a held output stall delays that load. Input stall is high except in idle.
// Configuration writes are taken at any cycle but are meant for idle time.
// ----------------------------------------------------------------------------
module percussive_click_synth (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pcs_pkg::t_in                   i_in,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pcs_pkg::t_out                  o_out,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcs_pkg::*;

    // configuration registers
    logic               r_click_enable;
    logic [LEVEL_W-1:0] r_tone_level;
    logic [LEVEL_W-1:0] r_noise_level;

    t_ctl_cmd    cmd;
    t_ctl_status status;

    // unknown index is dropped, wide data is masked by the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_enable <= RST_CLICK_ENABLE;
            r_tone_level   <= RST_TONE_LEVEL;
            r_noise_level  <= RST_NOISE_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLICK_ENABLE: r_click_enable <= i_cfg_data[0];
                CFG_TONE_LEVEL:   r_tone_level   <= i_cfg_data[LEVEL_W-1:0];
                CFG_NOISE_LEVEL:  r_noise_level  <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: decides each step, tracks whether a click is running
    pcs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_func         (i_in.func),
        .i_click_enable (r_click_enable),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_in_stall     (o_in_stall)
    );

    // arithmetic, click state and the output register
    pcs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_tone_level  (r_tone_level),
        .i_noise_level (r_noise_level),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out         (o_out),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

endmodule

FILE: tb/pcs_sample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcs_sample_checker
// Watches both channels and the register port of the click synthesizer,
// keeps its own click state, predicts every sample and compares in order.
// ----------------------------------------------------------------------------
module pcs_sample_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pcs_pkg::t_in                   i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pcs_pkg::t_out                  i_out,
    input  logic                           i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import pcs_pkg::*;

    // 3.5*log2(e) in q16
    localparam int unsigned LOG2E_35_Q16 = 330919;

    logic                click_en;
    logic [LEVEL_W-1:0]  tone_lvl;
    logic [LEVEL_W-1:0]  noise_lvl;

    logic                run_active;
    logic [IDX_W-1:0]    run_idx;
    logic [PERIOD_W-1:0] run_period;
    logic [PERIOD_W-1:0] run_phase;
    logic [31:0]         run_seed;

    t_out samples_due[$];
    int   fail_total = 0;
    int   due_total  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        fail_total++;
    endtask

    // knots of 2^(-j/16) in q15
    function automatic int unsigned env_knot(input int unsigned j);
        case (j)
            0:       return 32768;
            1:       return 31379;
            2:       return 30048;
            3:       return 28774;
            4:       return 27554;
            5:       return 26386;
            6:       return 25268;
            7:       return 24196;
            8:       return 23170;
            9:       return 22188;
            10:      return 21247;
            11:      return 20347;
            12:      return 19484;
            13:      return 18658;
            14:      return 17867;
            15:      return 17109;
            default: return 16384;
        endcase
    endfunction

    // exp(-3.5 i / n) as 2^-y, integer part as shift, fraction by interpolation
    function automatic int click_envelope(input logic [IDX_W-1:0] idx);
        int unsigned y, k, j, r, m, e;
        y = (idx * LOG2E_35_Q16) / CLICK_SAMPLES;
        k = y >> 16;
        j = (y >> 12) & 32'd15;
        r = y & 32'hFFF;
        m = env_knot(j) - (((env_knot(j) - env_knot(j + 1)) * r) >> 12);
        e = (k < 32) ? (m >> k) : 0;
        if (e > 32767)
            e = 32767;
        return int'(e);
    endfunction

    // advances the click state by one transfer, returns 1 when a sample is due
    function automatic bit predict_click_step(input t_in item, output t_out sample_out);
        int unsigned f, p;
        int          tone, noise, env, mix, raw;
        logic [31:0] x;
        bit          is_last;
        sample_out = '0;
        if (item.func == FUNC_START) begin
            if (!click_en)
                return 1'b0;
            f = item.freq;
            if (f == 0)
                f = DEFAULT_FREQ;
            p = SAMPLE_RATE / f;
            if (p < 2)
                p = 2;
            run_period = p[PERIOD_W-1:0];
            run_phase  = '0;
            run_idx    = '0;
            run_seed   = SEED_XOR ^ (f * SEED_MUL);
            run_active = 1'b1;
            return 1'b0;
        end
        if (!run_active)
            return 1'b0;

        tone  = (run_phase < (run_period >> 1)) ? int'(tone_lvl) : -int'(tone_lvl);
        noise = 0;
        env   = click_envelope(run_idx);
        if (run_idx < NOISE_SAMPLES) begin
            x = run_seed;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            run_seed = x;
            raw   = int'(x[15:0]);
            noise = ((raw - 32768) * int'(noise_lvl)) / 32768;
        end
        mix     = ((tone + noise) * env) / 32768;
        is_last = (int'(run_idx) + 1 >= int'(CLICK_SAMPLES));

        sample_out.sample = mix[15:0];
        sample_out.last   = is_last;

        run_phase = (int'(run_phase) + 1 >= int'(run_period)) ? '0 : run_phase + 1'b1;
        if (is_last) begin
            run_active = 1'b0;
            run_idx    = '0;
        end else begin
            run_idx = run_idx + 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out due;
        t_out predicted;
        if (!i_rst_n) begin
            click_en   = RST_CLICK_ENABLE;
            tone_lvl   = RST_TONE_LEVEL;
            noise_lvl  = RST_NOISE_LEVEL;
            run_active = 1'b0;
            run_idx    = '0;
            run_period = PERIOD_W'(2);
            run_phase  = '0;
            run_seed   = '0;
            samples_due.delete();
        end else begin
            // compare first so a sample is never matched against this edge's input
            if (i_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    report_mismatch("unexpected sample", int'(i_out.sample), 0);
                end else begin
                    due = samples_due.pop_front();
                    if (i_out.sample !== due.sample)
                        report_mismatch("sample", int'(i_out.sample), int'(due.sample));
                    if (i_out.last !== due.last)
                        report_mismatch("last", int'(i_out.last), int'(due.last));
                end
            end
            // an input transfer sees the register values from before this edge
            if (i_in_valid && !i_in_stall) begin
                if (predict_click_step(i_in, predicted))
                    samples_due.push_back(predicted);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLICK_ENABLE: click_en  = i_cfg_data[0];
                    CFG_TONE_LEVEL:   tone_lvl  = i_cfg_data[LEVEL_W-1:0];
                    CFG_NOISE_LEVEL:  noise_lvl = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
        due_total = samples_due.size();
    end

endmodule

FILE: tb/tb_percussive_click_synth.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_percussive_click_synth
// Drives start and tick transfers with random gaps and output back-pressure,
// steps the registers through several settings while the block is idle, and
// leaves prediction and comparison to the sample checker.
// ----------------------------------------------------------------------------
module tb_percussive_click_synth;
    import pcs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_GAP      = 13;
    // a start keeps the block busy through seed, division and period load, a tick through its sample steps
    localparam int IDLE_HOLD    = 32;
    localparam int RUN_LIMIT    = 600000;
    localparam int PHASE_ITEMS  = 500;
    localparam int PHASES       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int due_count;
    int cycle_count = 0;
    // when set, both sides run without gaps
    bit quiet = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    percussive_click_synth dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pcs_sample_checker sample_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (due_count)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: stall for a random number of cycles before each transfer
    initial begin : result_side
        int hold;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so back-to-back items keep it up
    task automatic send_item(input logic func, input logic [FREQ_W-1:0] freq);
        int  gap;
        t_in item;
        gap       = quiet ? 0 : $urandom_range(0, MAX_GAP);
        item.func = func;
        item.freq = freq;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // ticks carry random freq bits, which the block must ignore
    task automatic send_tick();
        int unsigned rnd;
        rnd = $urandom;
        send_item(FUNC_TICK, rnd[FREQ_W-1:0]);
    endtask

    task automatic send_start(input logic [FREQ_W-1:0] freq);
        send_item(FUNC_START, freq);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid, wait out every due sample, then let a pending start finish
    task automatic settle();
        in_valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (IDLE_HOLD) @(negedge clk);
    endtask

    // spread over full range, tone periods, long periods and corner frequencies
    function automatic logic [FREQ_W-1:0] pick_freq();
        int unsigned rnd;
        case ($urandom_range(0, 3))
            0: rnd = $urandom_range(0, 65535);
            1: rnd = $urandom_range(1, SAMPLE_RATE);
            2: rnd = $urandom_range(20, 600);
            default: begin
                case ($urandom_range(0, 8))
                    0:       rnd = 0;
                    1:       rnd = 1;
                    2:       rnd = 2;
                    3:       rnd = SAMPLE_RATE / 2 - 1;
                    4:       rnd = SAMPLE_RATE / 2;
                    5:       rnd = SAMPLE_RATE / 2 + 1;
                    6:       rnd = SAMPLE_RATE;
                    7:       rnd = SAMPLE_RATE + 1;
                    default: rnd = 65535;
                endcase
            end
        endcase
        return rnd[FREQ_W-1:0];
    endfunction

    initial begin : stimulus
        int unsigned        rnd;
        int                 left;
        int                 n;
        logic [LEVEL_W-1:0] tone_set;
        logic [LEVEL_W-1:0] noise_set;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset register values
        send_tick();                 // tick while idle gives nothing
        send_start(16'd0);           // zero frequency falls back to 2000 Hz
        repeat (3) send_tick();
        send_start(16'd65535);       // restart while a click runs, period clamps to 2
        repeat (2) send_tick();
        send_start(16'd1);           // longest period
        repeat (2) send_tick();
        send_start(16'd8000);        // period exactly 2
        send_tick();
        send_start(16'd16001);       // quotient 0, clamped
        send_tick();

        // enable write with upper data bits set; only bit 0 counts, so disabled
        settle();
        write_reg(CFG_CLICK_ENABLE, 14'h3FFE);
        send_tick();                 // running click keeps going while disabled
        send_start(16'd500);         // ignored while disabled
        send_tick();

        // write to an unmapped index is dropped, then re-enable
        settle();
        write_reg(CFG_UNMAPPED, 14'h1234);
        write_reg(CFG_CLICK_ENABLE, 14'h3FFF);
        send_start(16'd300);
        repeat (2) send_tick();

        // random part: one register setting per phase, extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    tone_set  = '1;
                    noise_set = '1;
                end
                1: begin
                    tone_set  = '0;
                    noise_set = '1;
                end
                2: begin
                    tone_set  = '1;
                    noise_set = '0;
                end
                default: begin
                    rnd       = $urandom;
                    tone_set  = rnd[LEVEL_W-1:0];
                    noise_set = rnd[LEVEL_W+15:16];
                end
            endcase
            settle();
            rnd = $urandom;
            write_reg(CFG_CLICK_ENABLE, {rnd[CFG_DATA_W-1:1], 1'b1});
            write_reg(CFG_TONE_LEVEL, tone_set);
            write_reg(CFG_NOISE_LEVEL, noise_set);

            left = PHASE_ITEMS;
            while (left > 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    // a few items of random kind and content
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        rnd = $urandom;
                        send_item(rnd[16], rnd[FREQ_W-1:0]);
                    end
                    left -= n;
                end else begin
                    send_start(pick_freq());
                    // mostly full clicks running a little past the end,
                    // otherwise cut short by the next start
                    if ($urandom_range(0, 4) < 3)
                        n = CLICK_SAMPLES + $urandom_range(0, 4);
                    else
                        n = $urandom_range(1, 150);
                    // keep the phase near its item budget
                    if (n > left - 1)
                        n = (left > 1) ? left - 1 : 1;
                    repeat (n) send_tick();
                    left -= ((n > int'(CLICK_SAMPLES)) ? int'(CLICK_SAMPLES) : n) + 1;
                end
            end
        end

        // drain and give the verdict
        quiet = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_ctrl.sv
rtl/core/pcs_dpath.sv
rtl/core/percussive_click_synth.sv
tb/pcs_sample_checker.sv
tb/tb_percussive_click_synth.sv
